FILE: sv/spt_pkg.sv
// Shared constants, types and state encoding for the shortest-first wait calculator.
`timescale 1ns / 1ps
package spt_pkg;

	localparam int MAX_JOBS = 64;
	localparam int DUR_W    = 16;
	localparam int IN_W     = 16;
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);
	localparam int CLK_W    = DUR_W + CNT_W;
	localparam int TOT_W    = CLK_W + $clog2(MAX_JOBS);
	localparam int WAIT_W   = 28;
	localparam int JOBS_W   = 7;

	localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};
	localparam logic [JOBS_W-1:0] JOBS_MAX = {JOBS_W{1'b1}};

	typedef logic [DUR_W-1:0] dur_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic shl;
		dur_t d;
		cnt_t held;
	} cell_ctrl_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} st_t;

endpackage

FILE: sv/spt_total_waiting_time.sv
// Top level: insertion chain, drain controller and result registers.
`timescale 1ns / 1ps
// Loading takes one word per cycle; busy stays low between words.
// After the last word the chain drains one job per cycle, so busy stays high
// while jobs are held, and done pulses in the cycle after the final drain step.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset clears the job count, the drop flag, the accumulator and the controller.
module spt_total_waiting_time (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [spt_pkg::IN_W-1:0]    duration,
	input  logic                        last,
	output logic                        done,
	output logic [spt_pkg::WAIT_W-1:0]  total_wait,
	output logic [spt_pkg::JOBS_W-1:0]  job_total,
	output logic                        overflow
);
	import spt_pkg::*;

	st_t              st_q, st_nxt;
	cnt_t             held_q;
	cnt_t             jobs_q;
	logic             dropped_q;
	logic             accept, full, ins, final_step;
	cell_ctrl_t       ctrl;
	dur_t             val_w [MAX_JOBS];
	logic             gt_w  [MAX_JOBS];
	logic [TOT_W-1:0] sum;
	logic             done_q;
	logic [WAIT_W-1:0] total_wait_q;
	logic [JOBS_W-1:0] job_total_q;
	logic             overflow_q;

	assign accept     = start && !busy;
	assign full       = held_q == CNT_W'(MAX_JOBS);
	assign ins        = accept && !full;
	assign final_step = (st_q == ST_DRAIN) && (held_q == CNT_W'(1));

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			ST_LOAD:  if (accept && last) st_nxt = ST_DRAIN;
			ST_DRAIN: if (final_step) st_nxt = ST_LOAD;
			default:  st_nxt = ST_LOAD;
		endcase
	end

	always_comb begin
		busy      = 1'b0;
		ctrl.ins  = 1'b0;
		ctrl.shl  = 1'b0;
		ctrl.d    = duration[DUR_W-1:0];
		ctrl.held = held_q;
		case (st_q)
			ST_LOAD:  ctrl.ins = ins;
			ST_DRAIN: begin
				busy     = 1'b1;
				ctrl.shl = 1'b1;
			end
			default:  busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_LOAD;
			held_q    <= '0;
			jobs_q    <= '0;
			dropped_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (st_q == ST_DRAIN) begin
				held_q <= held_q - CNT_W'(1);
				if (final_step) dropped_q <= 1'b0;
			end else if (accept) begin
				if (ins) held_q <= held_q + CNT_W'(1);
				else     dropped_q <= 1'b1;
				if (last) jobs_q <= ins ? held_q + CNT_W'(1) : held_q;
			end
		end
	end

	// The chain: cell 0 holds the smallest duration and feeds the accumulator.
	for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
		dur_t lv, rv;
		logic lg;
		if (i == 0) begin : g_first
			assign lv = '0;
			assign lg = 1'b0;
		end else begin : g_mid
			assign lv = val_w[i-1];
			assign lg = gt_w[i-1];
		end
		if (i == MAX_JOBS - 1) begin : g_end
			assign rv = '0;
		end else begin : g_inner
			assign rv = val_w[i+1];
		end
		spt_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.idx       (CNT_W'(i)),
			.left_val  (lv),
			.left_gt   (lg),
			.right_val (rv),
			.val       (val_w[i]),
			.gt        (gt_w[i])
		);
	end

	spt_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (st_q == ST_DRAIN),
		.clr    (final_step),
		.head   (val_w[0]),
		.sum    (sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= final_step;
		end
	end

	always_ff @(posedge clk) begin
		if (final_step) begin
			total_wait_q <= (sum > TOT_W'(WAIT_MAX)) ? WAIT_MAX : WAIT_W'(sum);
			job_total_q  <= (jobs_q > CNT_W'(JOBS_MAX)) ? JOBS_MAX : JOBS_W'(jobs_q);
			overflow_q   <= dropped_q;
		end
	end

	assign done       = done_q;
	assign total_wait = total_wait_q;
	assign job_total  = job_total_q;
	assign overflow   = overflow_q;

	a_done_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(st_q == ST_DRAIN))
		else $error("done without a preceding drain step");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DRAIN |-> held_q != '0)
		else $error("draining an empty chain");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		ins |=> held_q == $past(held_q) + CNT_W'(1))
		else $error("inserted word not counted");

endmodule

FILE: sv/spt_cell.sv
// One cell of the sorting chain: holds a single duration.
`timescale 1ns / 1ps
module spt_cell (
	input  logic              clk,
	input  spt_pkg::cell_ctrl_t ctrl,
	input  spt_pkg::cnt_t     idx,
	input  spt_pkg::dur_t     left_val,
	input  logic              left_gt,
	input  spt_pkg::dur_t     right_val,
	output spt_pkg::dur_t     val,
	output logic              gt
);
	import spt_pkg::*;

	dur_t val_q;
	logic occ;

	// An empty cell counts as larger than any new word.
	assign occ = idx < ctrl.held;
	assign gt  = !occ || (val_q > ctrl.d);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.shl) begin
			val_q <= right_val;
		end else if (ctrl.ins && gt) begin
			val_q <= left_gt ? left_val : ctrl.d;
		end
	end

endmodule

FILE: sv/spt_acc.sv
// Running start time and total wait, fed by the head of the chain.
`timescale 1ns / 1ps
module spt_acc (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         clr,
	input  spt_pkg::dur_t                head,
	output logic [spt_pkg::TOT_W-1:0]    sum
);
	import spt_pkg::*;

	logic [CLK_W-1:0] clock_q;
	logic [TOT_W-1:0] total_q;

	// Total as it stands after adding the start time of the current head.
	assign sum = total_q + TOT_W'(clock_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
			total_q <= '0;
		end else if (clr) begin
			clock_q <= '0;
			total_q <= '0;
		end else if (en) begin
			total_q <= sum;
			clock_q <= clock_q + CLK_W'(head);
		end
	end

endmodule
